FILE: hw/rtl/m3i_pkg.sv
// shared constants and index tables for the 3x3 matrix inverse unit
package m3i_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_ELEM       = 9;
  localparam int NUM_DET        = 3;
  localparam int FRONT_LAT      = 6;

  // adjugate element k = a[i0]*a[i1] - a[i2]*a[i3]
  localparam int COF_IDX [NUM_ELEM][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

  // first-row expansion: det = sum a[j] * adj[DET_COF[j]]
  localparam int DET_COF [NUM_DET] = '{0, 3, 6};

endpackage

FILE: hw/rtl/m3i_front.sv
// cofactor and determinant pipeline
module m3i_front #(
  parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [DATA_WIDTH-1:0]  a [m3i_pkg::NUM_ELEM],
  output logic                          out_valid,
  output logic signed [2*DATA_WIDTH:0]  cof [m3i_pkg::NUM_ELEM],
  output logic [3*DATA_WIDTH:0]         dmag,
  output logic                          dneg,
  output logic                          dzero
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 1;
  localparam int NE = m3i_pkg::NUM_ELEM;
  localparam int ND = m3i_pkg::NUM_DET;
  localparam int FL = m3i_pkg::FRONT_LAT;

  logic [FL-1:0]         vld;
  logic signed [PW-1:0]  pp   [NE];
  logic signed [PW-1:0]  pq   [NE];
  logic signed [CW-1:0]  cof2 [NE];
  logic signed [CW-1:0]  cof3 [NE];
  logic signed [CW-1:0]  cof4 [NE];
  logic signed [CW-1:0]  cof5 [NE];
  logic signed [W-1:0]   ad1  [ND];
  logic signed [W-1:0]   ad2  [ND];
  logic signed [CW-1:0]  ph   [ND];
  logic signed [CW-1:0]  pl   [ND];
  logic signed [DW-1:0]  term [ND];
  logic signed [DW-1:0]  dsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FL-2:0], in_valid};
    end
  end

  assign out_valid = vld[FL-1];

  always_ff @(posedge clk) begin
    for (int k = 0; k < NE; k++) begin
      pp[k]   <= a[m3i_pkg::COF_IDX[k][0]] * a[m3i_pkg::COF_IDX[k][1]];
      pq[k]   <= a[m3i_pkg::COF_IDX[k][2]] * a[m3i_pkg::COF_IDX[k][3]];
      cof2[k] <= CW'(pp[k]) - CW'(pq[k]);
      cof3[k] <= cof2[k];
      cof4[k] <= cof3[k];
      cof5[k] <= cof4[k];
      cof[k]  <= cof5[k];
    end
    for (int j = 0; j < ND; j++) begin
      ad1[j]  <= a[j];
      ad2[j]  <= ad1[j];
      ph[j]   <= ad2[j] * $signed(cof2[m3i_pkg::DET_COF[j]][CW-1:W]);
      pl[j]   <= ad2[j] * $signed({1'b0, cof2[m3i_pkg::DET_COF[j]][W-1:0]});
      term[j] <= {ph[j], {W{1'b0}}} + DW'(pl[j]);
    end
    dsum  <= term[0] + term[1] + term[2];
    dmag  <= dsum[DW-1] ? DW'(-dsum) : DW'(dsum);
    dneg  <= dsum[DW-1];
    dzero <= (dsum == '0);
  end

endmodule

FILE: hw/rtl/m3i_div_lane.sv
// one divider lane: adjugate element scaled and divided by the determinant
module m3i_div_lane #(
  parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic signed [2*DATA_WIDTH:0]  cof,
  input  logic                          dneg,
  input  logic [3*DATA_WIDTH:0]         dmag_in,
  input  logic [3*DATA_WIDTH:0]         dmag_stage [DATA_WIDTH],
  output logic [DATA_WIDTH-1:0]         val,
  output logic                          sat
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 1;
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int RW = (NW > DW + W) ? NW : DW + W;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic [RW-1:0] rem [W+1];
  logic [W-1:0]  quo [W+1];
  logic          ovf [W+1];
  logic          neg [W+1];
  logic [CW-1:0] mag;
  logic [RW-1:0] num;
  logic [RW-1:0] dtop;
  logic          fits;
  logic [W-1:0]  qf;

  assign mag  = cof[CW-1] ? CW'(-cof) : CW'(cof);
  assign num  = RW'({mag, {(2*FRAC_BITS){1'b0}}});
  assign dtop = RW'(dmag_in) << W;

  always_ff @(posedge clk) begin
    rem[0] <= num;
    quo[0] <= '0;
    ovf[0] <= (num >= dtop);
    neg[0] <= cof[CW-1] ^ dneg;
  end

  for (genvar j = 0; j < W; j++) begin : g_step
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(dmag_stage[j]) << (W - 1 - j);
    assign ge  = (rem[j] >= dsh);
    always_ff @(posedge clk) begin
      rem[j+1] <= ge ? rem[j] - dsh : rem[j];
      quo[j+1] <= {quo[j][W-2:0], ge};
      ovf[j+1] <= ovf[j];
      neg[j+1] <= neg[j];
    end
  end

  assign qf   = quo[W];
  assign fits = !ovf[W] && (!qf[W-1] || (neg[W] && (qf[W-2:0] == '0)));

  always_ff @(posedge clk) begin
    if (fits) begin
      val <= neg[W] ? W'(-qf) : qf;
    end else begin
      val <= neg[W] ? SMIN : SMAX;
    end
    sat <= !fits;
  end

endmodule

FILE: hw/rtl/matrix3_inverse_unit.sv
// 3x3 matrix inverse top level: cofactor front end, nine divider lanes, merge
// throughput: one matrix per cycle, busy never rises; done is a one-cycle strobe
// path: 6 front, DATA_WIDTH + 2 divider stages (DATA_WIDTH quotient bits), 1 merge
// reset: synchronous, clears the valid pipeline only; in-flight transactions are dropped
module matrix3_inverse_unit #(
  parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [DATA_WIDTH-1:0]  a00,
  input  logic signed [DATA_WIDTH-1:0]  a01,
  input  logic signed [DATA_WIDTH-1:0]  a02,
  input  logic signed [DATA_WIDTH-1:0]  a10,
  input  logic signed [DATA_WIDTH-1:0]  a11,
  input  logic signed [DATA_WIDTH-1:0]  a12,
  input  logic signed [DATA_WIDTH-1:0]  a20,
  input  logic signed [DATA_WIDTH-1:0]  a21,
  input  logic signed [DATA_WIDTH-1:0]  a22,
  output logic                          done,
  output logic signed [DATA_WIDTH-1:0]  inv00,
  output logic signed [DATA_WIDTH-1:0]  inv01,
  output logic signed [DATA_WIDTH-1:0]  inv02,
  output logic signed [DATA_WIDTH-1:0]  inv10,
  output logic signed [DATA_WIDTH-1:0]  inv11,
  output logic signed [DATA_WIDTH-1:0]  inv12,
  output logic signed [DATA_WIDTH-1:0]  inv20,
  output logic signed [DATA_WIDTH-1:0]  inv21,
  output logic signed [DATA_WIDTH-1:0]  inv22,
  output logic signed [DATA_WIDTH-1:0]  determinant,
  output logic                          singular,
  output logic                          saturated
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 1;
  localparam int NE = m3i_pkg::NUM_ELEM;
  localparam int LL = W + 2;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0]   a_arr [NE];
  logic                  f_valid;
  logic signed [CW-1:0]  f_cof [NE];
  logic [DW-1:0]         f_dmag;
  logic                  f_dneg;
  logic                  f_dzero;
  logic [DW-1:0]         d_pipe [W];
  logic                  v_l [LL];
  logic                  z_l [LL];
  logic                  dn0;
  logic [W-1:0]          dv_l [1:LL-1];
  logic                  ds_l [1:LL-1];
  logic [DW-1:0]         dq;
  logic                  dfits;
  logic [W-1:0]          lane_val [NE];
  logic [NE-1:0]         lane_sat;
  logic [W-1:0]          inv_r [NE];
  logic [W-1:0]          det_r;
  logic                  sing_r;
  logic                  sat_r;

  assign busy = 1'b0;

  assign a_arr[0] = a00;
  assign a_arr[1] = a01;
  assign a_arr[2] = a02;
  assign a_arr[3] = a10;
  assign a_arr[4] = a11;
  assign a_arr[5] = a12;
  assign a_arr[6] = a20;
  assign a_arr[7] = a21;
  assign a_arr[8] = a22;

  m3i_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .a        (a_arr),
    .out_valid(f_valid),
    .cof      (f_cof),
    .dmag     (f_dmag),
    .dneg     (f_dneg),
    .dzero    (f_dzero)
  );

  // determinant magnitude travels beside the quotient bits
  always_ff @(posedge clk) begin
    d_pipe[0] <= f_dmag;
    for (int j = 1; j < W; j++) begin
      d_pipe[j] <= d_pipe[j-1];
    end
  end

  for (genvar k = 0; k < NE; k++) begin : g_lane
    m3i_div_lane #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .cof       (f_cof[k]),
      .dneg      (f_dneg),
      .dmag_in   (f_dmag),
      .dmag_stage(d_pipe),
      .val       (lane_val[k]),
      .sat       (lane_sat[k])
    );
  end

  // determinant field from the first registered magnitude
  assign dq    = d_pipe[0] >> (2 * FRAC_BITS);
  assign dfits = (dq[DW-1:W] == '0) && (!dq[W-1] || (dn0 && (dq[W-2:0] == '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < LL; s++) begin
        v_l[s] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      v_l[0] <= f_valid;
      for (int s = 1; s < LL; s++) begin
        v_l[s] <= v_l[s-1];
      end
      done <= v_l[LL-1];
    end
  end

  always_ff @(posedge clk) begin
    z_l[0] <= f_dzero;
    dn0    <= f_dneg;
    for (int s = 1; s < LL; s++) begin
      z_l[s] <= z_l[s-1];
    end
    if (dfits) begin
      dv_l[1] <= dn0 ? W'(-dq[W-1:0]) : dq[W-1:0];
    end else begin
      dv_l[1] <= dn0 ? SMIN : SMAX;
    end
    ds_l[1] <= !dfits;
    for (int s = 2; s < LL; s++) begin
      dv_l[s] <= dv_l[s-1];
      ds_l[s] <= ds_l[s-1];
    end
  end

  // merge: singular forces zeros, saturation gathered over all lanes and the determinant
  always_ff @(posedge clk) begin
    for (int k = 0; k < NE; k++) begin
      inv_r[k] <= z_l[LL-1] ? '0 : lane_val[k];
    end
    det_r  <= dv_l[LL-1];
    sing_r <= z_l[LL-1];
    sat_r  <= !z_l[LL-1] && ((|lane_sat) || ds_l[LL-1]);
  end

  assign inv00       = inv_r[0];
  assign inv01       = inv_r[1];
  assign inv02       = inv_r[2];
  assign inv10       = inv_r[3];
  assign inv11       = inv_r[4];
  assign inv12       = inv_r[5];
  assign inv20       = inv_r[6];
  assign inv21       = inv_r[7];
  assign inv22       = inv_r[8];
  assign determinant = det_r;
  assign singular    = sing_r;
  assign saturated   = sat_r;

endmodule

FILE: hw/rtl/m3i_checker.sv
// port-level checks for the matrix inverse unit, bound to the top level
module m3i_checker #(
  parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic signed [DATA_WIDTH-1:0]  inv00,
  input logic signed [DATA_WIDTH-1:0]  inv01,
  input logic signed [DATA_WIDTH-1:0]  inv02,
  input logic signed [DATA_WIDTH-1:0]  inv10,
  input logic signed [DATA_WIDTH-1:0]  inv11,
  input logic signed [DATA_WIDTH-1:0]  inv12,
  input logic signed [DATA_WIDTH-1:0]  inv20,
  input logic signed [DATA_WIDTH-1:0]  inv21,
  input logic signed [DATA_WIDTH-1:0]  inv22,
  input logic signed [DATA_WIDTH-1:0]  determinant,
  input logic                          singular,
  input logic                          saturated
);

  localparam int W   = DATA_WIDTH;
  localparam int LAT = DATA_WIDTH + 9;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic ext00, ext01, ext02, ext10, ext11, ext12, ext20, ext21, ext22, extd;
  logic zero_all;

  assign ext00 = (inv00 == SMAX) || (inv00 == SMIN);
  assign ext01 = (inv01 == SMAX) || (inv01 == SMIN);
  assign ext02 = (inv02 == SMAX) || (inv02 == SMIN);
  assign ext10 = (inv10 == SMAX) || (inv10 == SMIN);
  assign ext11 = (inv11 == SMAX) || (inv11 == SMIN);
  assign ext12 = (inv12 == SMAX) || (inv12 == SMIN);
  assign ext20 = (inv20 == SMAX) || (inv20 == SMIN);
  assign ext21 = (inv21 == SMAX) || (inv21 == SMIN);
  assign ext22 = (inv22 == SMAX) || (inv22 == SMIN);
  assign extd  = (determinant == SMAX) || (determinant == SMIN);

  assign zero_all = (inv00 == '0) && (inv01 == '0) && (inv02 == '0) &&
                    (inv10 == '0) && (inv11 == '0) && (inv12 == '0) &&
                    (inv20 == '0) && (inv21 == '0) && (inv22 == '0) &&
                    (determinant == '0);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("transaction without result at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching transaction");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    done && singular |-> zero_all && !saturated)
    else $error("singular result carries nonzero values");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> ext00 || ext01 || ext02 || ext10 || ext11 || ext12 ||
                          ext20 || ext21 || ext22 || extd)
    else $error("saturated flag without a clamped value");

endmodule

bind matrix3_inverse_unit m3i_checker #(
  .DATA_WIDTH(DATA_WIDTH),
  .FRAC_BITS (FRAC_BITS)
) chk (.*);

FILE: test/tb.sv
// testbench for the 3x3 matrix inverse unit: random and corner matrices checked against a predictor
module tb;

  localparam int NUM_ELEM = m3i_pkg::NUM_ELEM;
  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LIMIT = 400000;

  typedef logic signed [DW-1:0] mat_t [NUM_ELEM];
  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic [DW-1:0] inv [NUM_ELEM];
    logic [DW-1:0] det;
    logic          sing;
    logic          sat;
  } inverse_t;

  class inverse_board;
    inverse_t pending_q [$];
    int errors = 0;

    function automatic logic [DW-1:0] clamp(wide_t v, inout bit sat);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (DW - 1)) - 1;
      lo = -(wide_t'(1) <<< (DW - 1));
      if (v > hi) begin
        sat = 1;
        return hi[DW-1:0];
      end
      if (v < lo) begin
        sat = 1;
        return lo[DW-1:0];
      end
      return v[DW-1:0];
    endfunction

    function automatic void note(mat_t m);
      wide_t a [NUM_ELEM];
      wide_t adj [NUM_ELEM];
      wide_t d, q;
      logic [159:0] num, den;
      bit sat;
      inverse_t r;
      sat = 0;
      for (int i = 0; i < NUM_ELEM; i++) a[i] = wide_t'(m[i]);
      adj[0] = a[4] * a[8] - a[5] * a[7];
      adj[1] = a[2] * a[7] - a[1] * a[8];
      adj[2] = a[1] * a[5] - a[2] * a[4];
      adj[3] = a[5] * a[6] - a[3] * a[8];
      adj[4] = a[0] * a[8] - a[2] * a[6];
      adj[5] = a[2] * a[3] - a[0] * a[5];
      adj[6] = a[3] * a[7] - a[4] * a[6];
      adj[7] = a[1] * a[6] - a[0] * a[7];
      adj[8] = a[0] * a[4] - a[1] * a[3];
      d = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
      if (d == 0) begin
        for (int i = 0; i < NUM_ELEM; i++) r.inv[i] = '0;
        r.det = '0;
        r.sing = 1;
        r.sat = 0;
      end else begin
        den = d < 0 ? -d : d;
        for (int i = 0; i < NUM_ELEM; i++) begin
          num = (adj[i] < 0 ? -adj[i] : adj[i]);
          num = num << (2 * FB);
          q = wide_t'(num / den);
          if ((adj[i] < 0) != (d < 0)) q = -q;
          r.inv[i] = clamp(q, sat);
        end
        q = wide_t'(den >> (2 * FB));
        if (d < 0) q = -q;
        r.det = clamp(q, sat);
        r.sing = 0;
        r.sat = sat;
      end
      pending_q.push_back(r);
    endfunction

    function automatic void check(inverse_t act);
      inverse_t e;
      if (pending_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      for (int i = 0; i < NUM_ELEM; i++)
        if (act.inv[i] !== e.inv[i]) begin
          $error("inv%0d%0d expected %h actual %h", i / 3, i % 3, e.inv[i], act.inv[i]);
          errors++;
        end
      if (act.det !== e.det) begin
        $error("determinant expected %h actual %h", e.det, act.det);
        errors++;
      end
      if (act.sing !== e.sing) begin
        $error("singular expected %b actual %b", e.sing, act.sing);
        errors++;
      end
      if (act.sat !== e.sat) begin
        $error("saturated expected %b actual %b", e.sat, act.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done, singular, saturated;
  logic signed [DW-1:0] a00 = 0, a01 = 0, a02 = 0, a10 = 0, a11 = 0, a12 = 0;
  logic signed [DW-1:0] a20 = 0, a21 = 0, a22 = 0;
  logic signed [DW-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  logic signed [DW-1:0] determinant;
  int cycles = 0;
  int stall_phase = 0;
  inverse_board board = new();

  always #1 clk = ~clk;

  matrix3_inverse_unit uut (
    .clk, .rst, .start, .busy,
    .a00, .a01, .a02, .a10, .a11, .a12, .a20, .a21, .a22,
    .done,
    .inv00, .inv01, .inv02, .inv10, .inv11, .inv12, .inv20, .inv21, .inv22,
    .determinant, .singular, .saturated
  );

  always @(posedge clk) begin
    inverse_t act;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (!rst && start && !busy)
      board.note('{a00, a01, a02, a10, a11, a12, a20, a21, a22});
    if (!rst && done) begin
      act.inv = '{inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22};
      act.det = determinant;
      act.sing = singular;
      act.sat = saturated;
      board.check(act);
    end
  end

  task automatic send(mat_t m);
    {a00, a01, a02, a10, a11, a12, a20, a21, a22} <= {m[0], m[1], m[2], m[3], m[4],
                                                      m[5], m[6], m[7], m[8]};
    start <= 1;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic mat_t diag(logic signed [DW-1:0] v);
    mat_t m;
    for (int i = 0; i < NUM_ELEM; i++) m[i] = (i % 4 == 0) ? v : '0;
    return m;
  endfunction

  function automatic mat_t random_matrix();
    mat_t m;
    int kind;
    int lim;
    kind = $urandom_range(0, 9);
    lim = $urandom_range(0, 3) == 0 ? 32'h7fff : 32'h3ffff;
    for (int i = 0; i < NUM_ELEM; i++) begin
      case (kind)
        0, 1: m[i] = $urandom;
        2: m[i] = $signed($urandom_range(0, 16)) - 8;
        3: m[i] = ((i % 4 == 0) ? 32'sh40000 : 0) + $signed($urandom_range(0, 2 * lim)) - lim;
        default: m[i] = $signed($urandom_range(0, 2 * lim)) - lim;
      endcase
    end
    if (kind == 4) for (int i = 0; i < 3; i++) m[6 + i] = m[i];
    if (kind == 5) for (int i = 0; i < 3; i++) m[3 * i + 2] = -m[3 * i];
    return m;
  endfunction

  initial begin
    mat_t m;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(diag(32'sh10000));
    send(diag(32'sh0));
    send(diag(32'sh1));
    send(diag(-32'sh1));
    send(diag(32'sh100));
    send(diag(32'sh7fffffff));
    send(diag(32'sh80000000));
    send(diag(-32'sh20000));
    for (int i = 0; i < NUM_ELEM; i++) m[i] = 32'sh80000000;
    send(m);
    for (int i = 0; i < NUM_ELEM; i++) m[i] = 32'sh7fffffff;
    send(m);
    m = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000, 32'sh60000,
          32'sh70000, 32'sh80000, 32'sh90000};
    send(m);
    m = '{32'sh20000, 32'sh10000, 0, 32'sh10000, 32'sh20000, 32'sh10000,
          0, 32'sh10000, 32'sh20000};
    send(m);
    m = '{0, 32'sh10000, 0, 32'sh10000, 0, 0, 0, 0, 32'sh10000};
    send(m);
    m = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
          32'sh80000000, 32'sh1, 32'sh0, 32'shffffffff};
    send(m);
    m = diag(32'sh10000);
    m[4] = 32'sh1;
    send(m);
    drain();

    for (int n = 0; n < 1600; ) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < 1600; k++, n++) send(random_matrix());
      stall_phase = (stall_phase + 1) % 5;
      if (stall_phase == 0) pause($urandom_range(20, 60));
      else if (stall_phase != 3) pause($urandom_range(0, 6));
      if (n > 800 && n < 840) drain();
    end

    drain();
    repeat (DW + 20) @(posedge clk);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/m3i_pkg.sv
hw/rtl/m3i_front.sv
hw/rtl/m3i_div_lane.sv
hw/rtl/matrix3_inverse_unit.sv
hw/rtl/m3i_checker.sv
test/tb.sv
